// ===== hdl/lrst_pkg.sv =====
// ----------------------------------------------------------------------------
// lrst_pkg
// Shared types and constants of the ranked sorted learning table: the stored
// entry, the command broadcast to the cell row, status and register codes.
// ----------------------------------------------------------------------------
package lrst_pkg;

  localparam int DEF_MAX_ENTRIES = 256;
  localparam int TREE_GROUP      = 16;
  localparam int CFG_DW          = 9;

  localparam logic [CFG_DW-1:0] CAP_RESET = 9'd256;

  localparam logic [2:0] ST_NORMAL      = 3'd0;
  localparam logic [2:0] ST_EVICTED     = 3'd1;
  localparam logic [2:0] ST_OFFSET_ZERO = 3'd2;
  localparam logic [2:0] ST_NO_DICT     = 3'd3;
  localparam logic [2:0] ST_ERROR       = 3'd4;

  typedef enum logic [0:0] {
    REG_DICT_PRESENT = 1'b0,
    REG_CAPACITY     = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOOK,
    OP_HIT,
    OP_EVICT,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    logic [15:0] seg;
    logic [15:0] offset;
    logic [7:0]  dict_id;
    logic [3:0]  kanji_start;
    logic [1:0]  kana_kanji;
    logic        number_flag;
  } entry_t;

  typedef struct packed {
    cell_op_t    op;
    logic [15:0] seg;
    logic [15:0] offset;
    logic [7:0]  dict_id;
    logic [3:0]  kanji_start;
    logic [1:0]  kana_kanji;
    logic        number_flag;
    logic        start_valid;
    logic        kana_valid;
    logic        age;
  } cmd_t;

endpackage

// ===== hdl/lrst_cell.sv =====
// ----------------------------------------------------------------------------
// lrst_cell
// One slot of the sorted table. It compares its entry with the broadcast key,
// ages its rank, and shifts entries to or from its neighbors.
// ----------------------------------------------------------------------------
module lrst_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9,
  parameter int IW  = 8
) (
  input  logic              clk,
  input  lrst_pkg::cmd_t    cmd,
  input  logic [CW-1:0]     count,
  input  logic [CW-1:0]     hit_rank,
  input  logic [IW-1:0]     vic_idx,
  input  lrst_pkg::entry_t  left_ent,
  input  logic [CW-1:0]     left_rank,
  input  logic              left_le,
  input  lrst_pkg::entry_t  right_ent,
  input  logic [CW-1:0]     right_rank,
  output lrst_pkg::entry_t  ent,
  output logic [CW-1:0]     rank,
  output logic              le,
  output logic              hit,
  output logic [CW-1:0]     hit_rank_m,
  output logic [IW-1:0]     vic_idx_m
);
  import lrst_pkg::*;

  localparam logic [CW-1:0] MY_POS   = CW'(IDX);
  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [CW-1:0] RANK_ONE = CW'(1);

  logic          valid;
  logic          match;
  logic [CW-1:0] age_inc;
  entry_t        ent_new;
  entry_t        ent_next;
  logic [CW-1:0] rank_next;

  assign valid   = count > MY_POS;
  assign match   = valid && ent.seg == cmd.seg && ent.offset == cmd.offset &&
                   ent.dict_id == cmd.dict_id;
  assign le      = valid && (ent.seg < cmd.seg ||
                   (ent.seg == cmd.seg && ent.offset <= cmd.offset));
  assign age_inc = {{(CW-1){1'b0}}, cmd.age};

  always_comb begin
    ent_new.seg         = cmd.seg;
    ent_new.offset      = cmd.offset;
    ent_new.dict_id     = cmd.dict_id;
    ent_new.kanji_start = cmd.start_valid ? cmd.kanji_start : 4'd0;
    ent_new.kana_kanji  = cmd.kana_valid ? cmd.kana_kanji : 2'd0;
    ent_new.number_flag = cmd.number_flag;
  end

  always_comb begin
    ent_next  = ent;
    rank_next = rank;
    unique case (cmd.op)
      OP_HIT: begin
        if (hit) begin
          rank_next = RANK_ONE;
          if (cmd.start_valid) ent_next.kanji_start = cmd.kanji_start;
          if (cmd.kana_valid) ent_next.kana_kanji = cmd.kana_kanji;
          ent_next.number_flag = cmd.number_flag;
        end else if (valid && rank < hit_rank) begin
          rank_next = rank + RANK_ONE;
        end
      end
      OP_EVICT: begin
        if (MY_IDX >= vic_idx) begin
          ent_next  = right_ent;
          rank_next = right_rank + RANK_ONE;
        end else begin
          rank_next = rank + RANK_ONE;
        end
      end
      OP_INSERT: begin
        if (le) begin
          rank_next = rank + age_inc;
        end else if (left_le) begin
          ent_next  = ent_new;
          rank_next = RANK_ONE;
        end else begin
          ent_next  = left_ent;
          rank_next = left_rank + age_inc;
        end
      end
      default: begin
        ent_next  = ent;
        rank_next = rank;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent  <= ent_next;
    rank <= rank_next;
    if (cmd.op == OP_LOOK) begin
      hit        <= match;
      hit_rank_m <= match ? rank : '0;
      vic_idx_m  <= (valid && rank == count) ? MY_IDX : '0;
    end
  end

endmodule

// ===== hdl/lrst_match_tree.sv =====
// ----------------------------------------------------------------------------
// lrst_match_tree
// Two-level registered OR tree that gathers the one-hot hit flag, the rank of
// the hit entry and the index of the oldest entry from the cell row.
// ----------------------------------------------------------------------------
module lrst_match_tree #(
  parameter int N   = 256,
  parameter int CW  = 9,
  parameter int IW  = 8,
  parameter int GRP = 16
) (
  input  logic          clk,
  input  logic          hit_vec [N],
  input  logic [CW-1:0] rank_m  [N],
  input  logic [IW-1:0] idx_m   [N],
  output logic          any_hit,
  output logic [CW-1:0] hit_rank,
  output logic [IW-1:0] vic_idx
);

  localparam int NG = (N + GRP - 1) / GRP;

  logic          grp_hit       [NG];
  logic [CW-1:0] grp_rank      [NG];
  logic [IW-1:0] grp_idx       [NG];
  logic          grp_hit_next  [NG];
  logic [CW-1:0] grp_rank_next [NG];
  logic [IW-1:0] grp_idx_next  [NG];
  logic          any_hit_next;
  logic [CW-1:0] hit_rank_next;
  logic [IW-1:0] vic_idx_next;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_next[g]  = 1'b0;
      grp_rank_next[g] = '0;
      grp_idx_next[g]  = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < N) begin
          grp_hit_next[g]  = grp_hit_next[g] | hit_vec[g * GRP + k];
          grp_rank_next[g] = grp_rank_next[g] | rank_m[g * GRP + k];
          grp_idx_next[g]  = grp_idx_next[g] | idx_m[g * GRP + k];
        end
      end
    end
  end

  always_comb begin
    any_hit_next  = 1'b0;
    hit_rank_next = '0;
    vic_idx_next  = '0;
    for (int g = 0; g < NG; g++) begin
      any_hit_next  = any_hit_next | grp_hit[g];
      hit_rank_next = hit_rank_next | grp_rank[g];
      vic_idx_next  = vic_idx_next | grp_idx[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_hit  <= grp_hit_next;
    grp_rank <= grp_rank_next;
    grp_idx  <= grp_idx_next;
    any_hit  <= any_hit_next;
    hit_rank <= hit_rank_next;
    vic_idx  <= vic_idx_next;
  end

endmodule

// ===== hdl/lru_ranked_sorted_learning_table_core.sv =====
// ----------------------------------------------------------------------------
// lru_ranked_sorted_learning_table_core
// Learning table kept sorted by segment and offset in a row of cells, each
// entry with a recency rank. Hits refresh the entry, misses insert it and
// evict the oldest entry when the table is full (an error if capacity is 0).
//
//   channel   signals                                  direction
//   in        in_valid/in_ready, seg .. kana_valid     request in
//   out       out_valid/out_ready, status, was_hit     result out
//   cfg       cfg_write, cfg_index, cfg_data           register write
//
// A looked-up request runs LOOK, RED1, RED2, DECIDE, FINISH before the next
// acceptance, with INSERT after DECIDE when the oldest entry is evicted; the
// compare step and the two match tree levels set this. A request refused for
// no dictionary or offset zero goes straight to FINISH. The result register
// frees the input side at once, but a new result waits while the previous
// one is not taken. Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_ranked_sorted_learning_table_core #(
  parameter int MAX_ENTRIES = lrst_pkg::DEF_MAX_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 seg,
  input  logic [15:0]                 offset,
  input  logic [7:0]                  dict_id,
  input  logic [3:0]                  kanji_start,
  input  logic [1:0]                  kana_kanji,
  input  logic                        number_flag,
  input  logic                        start_valid,
  input  logic                        kana_valid,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  status,
  output logic                        was_hit,
  input  logic                        cfg_write,
  input  lrst_pkg::reg_idx_t          cfg_index,
  input  logic [lrst_pkg::CFG_DW-1:0] cfg_data
);
  import lrst_pkg::*;

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CAPW = (CW > CFG_DW) ? CW : CFG_DW;

  localparam logic [CW-1:0]   COUNT_ONE = CW'(1);
  localparam logic [CAPW-1:0] CAP_LIMIT = CAPW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_RED1,
    S_RED2,
    S_DECIDE,
    S_INSERT,
    S_FINISH
  } state_t;

  state_t              state;
  logic                dict_present;
  logic [CFG_DW-1:0]   capacity;
  logic [CW-1:0]       count;
  logic [2:0]          res_status;
  logic                res_hit;

  logic [15:0]         req_seg;
  logic [15:0]         req_offset;
  logic [7:0]          req_dict_id;
  logic [3:0]          req_kanji_start;
  logic [1:0]          req_kana_kanji;
  logic                req_number_flag;
  logic                req_start_valid;
  logic                req_kana_valid;

  cmd_t                cmd;
  logic [CAPW-1:0]     cap_ext;
  logic [CAPW-1:0]     cap_eff;
  logic                full;
  logic                cap_zero;

  logic                any_hit;
  logic [CW-1:0]       hit_rank;
  logic [IW-1:0]       vic_idx;

  entry_t              ent_a   [MAX_ENTRIES];
  logic [CW-1:0]       rank_a  [MAX_ENTRIES];
  logic                le_a    [MAX_ENTRIES];
  logic                hit_a   [MAX_ENTRIES];
  logic [CW-1:0]       hrm_a   [MAX_ENTRIES];
  logic [IW-1:0]       vim_a   [MAX_ENTRIES];

  assign in_ready = (state == S_IDLE);

  assign cap_ext  = CAPW'(capacity);
  assign cap_eff  = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;
  assign full     = CAPW'(count) >= cap_eff;
  assign cap_zero = (cap_eff == '0);

  always_comb begin
    cmd.seg         = req_seg;
    cmd.offset      = req_offset;
    cmd.dict_id     = req_dict_id;
    cmd.kanji_start = req_kanji_start;
    cmd.kana_kanji  = req_kana_kanji;
    cmd.number_flag = req_number_flag;
    cmd.start_valid = req_start_valid;
    cmd.kana_valid  = req_kana_valid;
    cmd.age         = (state == S_DECIDE);
    unique case (state)
      S_LOOK: cmd.op = OP_LOOK;
      S_DECIDE: begin
        if (any_hit) cmd.op = OP_HIT;
        else if (!full) cmd.op = OP_INSERT;
        else if (cap_zero) cmd.op = OP_IDLE;
        else cmd.op = OP_EVICT;
      end
      S_INSERT: cmd.op = OP_INSERT;
      default: cmd.op = OP_IDLE;
    endcase
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam int LI = (i == 0) ? 0 : i - 1;
    localparam int RI = (i == MAX_ENTRIES - 1) ? i : i + 1;
    lrst_cell #(
      .IDX (i),
      .CW  (CW),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .hit_rank   (hit_rank),
      .vic_idx    (vic_idx),
      .left_ent   (ent_a[LI]),
      .left_rank  (rank_a[LI]),
      .left_le    ((i == 0) ? 1'b1 : le_a[LI]),
      .right_ent  (ent_a[RI]),
      .right_rank (rank_a[RI]),
      .ent        (ent_a[i]),
      .rank       (rank_a[i]),
      .le         (le_a[i]),
      .hit        (hit_a[i]),
      .hit_rank_m (hrm_a[i]),
      .vic_idx_m  (vim_a[i])
    );
  end

  lrst_match_tree #(
    .N   (MAX_ENTRIES),
    .CW  (CW),
    .IW  (IW),
    .GRP (TREE_GROUP)
  ) u_tree (
    .clk      (clk),
    .hit_vec  (hit_a),
    .rank_m   (hrm_a),
    .idx_m    (vim_a),
    .any_hit  (any_hit),
    .hit_rank (hit_rank),
    .vic_idx  (vic_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dict_present <= 1'b0;
      capacity     <= CAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DICT_PRESENT: dict_present <= cfg_data[0];
        REG_CAPACITY:     capacity     <= cfg_data;
        default:          capacity     <= capacity;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_seg         <= seg;
            req_offset      <= offset;
            req_dict_id     <= dict_id;
            req_kanji_start <= kanji_start;
            req_kana_kanji  <= kana_kanji;
            req_number_flag <= number_flag;
            req_start_valid <= start_valid;
            req_kana_valid  <= kana_valid;
            res_hit         <= 1'b0;
            priority if (!dict_present) begin
              res_status <= ST_NO_DICT;
              state      <= S_FINISH;
            end else if (offset == 16'd0) begin
              res_status <= ST_OFFSET_ZERO;
              state      <= S_FINISH;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: state <= S_RED1;
        S_RED1: state <= S_RED2;
        S_RED2: state <= S_DECIDE;
        S_DECIDE: begin
          priority if (any_hit) begin
            res_status <= ST_NORMAL;
            res_hit    <= 1'b1;
            state      <= S_FINISH;
          end else if (!full) begin
            res_status <= ST_NORMAL;
            count      <= count + COUNT_ONE;
            state      <= S_FINISH;
          end else if (cap_zero) begin
            res_status <= ST_ERROR;
            state      <= S_FINISH;
          end else begin
            res_status <= ST_EVICTED;
            count      <= count - COUNT_ONE;
            state      <= S_INSERT;
          end
        end
        S_INSERT: begin
          count <= count + COUNT_ONE;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            was_hit   <= res_hit;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
